// ----- rtl/core/lrk_pkg.sv -----
// Package for the LCD refresh and keypad scanner: sizes, command and
// register codes, reset values, the high character remap table and the
// structs passed between the submodules. No dependencies.
`default_nettype none

package lrk_pkg;

  localparam int LineChars  = 16;
  localparam int KeyColumns = 4;

  localparam int BufLen  = 2 * LineChars;
  localparam int BufIdxW = $clog2(BufLen);
  localparam int PosW    = $clog2(BufLen + 1);
  localparam int ColW    = (KeyColumns > 1) ? $clog2(KeyColumns) : 1;
  localparam int MaskW   = 16;
  localparam int KeyLinesW = 4;

  localparam int CmdW    = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_WRITE_CHAR = 3'd1,
    CMD_SET_MASK   = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_TAKE_KEY   = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPEAT_EN    = 3'd0,
    CFG_SECOND_TICKS = 3'd1,
    CFG_BLINK_TICKS  = 3'd2,
    CFG_REP_DELAY    = 3'd3,
    CFG_REP_PERIOD   = 3'd4,
    CFG_BEEP_TICKS   = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] SecondTicksRst = 16'd1000;
  localparam logic [15:0] BlinkTicksRst  = 16'd300;
  localparam logic [15:0] BlinkCntRst    = 16'd500;
  localparam logic [15:0] RepDelayRst    = 16'd700;
  localparam logic [15:0] RepPeriodRst   = 16'd150;
  localparam logic [7:0]  BeepTicksRst   = 8'd100;

  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] LcdLineOne   = 8'h80;
  localparam logic [7:0] LcdLineTwo   = 8'hC0;

  localparam logic [7:0] CODE_TABLE [128] = '{
    8'hD9,8'hDA,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'hA2,8'hB5,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h41,8'hA0,8'h42,8'hA1,8'hE0,8'h45,8'hA3,8'hA4,
    8'hA5,8'hA6,8'h4B,8'hA7,8'h4D,8'h48,8'h4F,8'hA8,
    8'h50,8'h43,8'h54,8'hA9,8'hAA,8'h58,8'hE1,8'hAB,
    8'hAC,8'hE2,8'hAD,8'hAE,8'h62,8'hAF,8'hB0,8'hB1,
    8'h61,8'hB2,8'hB3,8'hB4,8'hE3,8'h65,8'hB6,8'hB7,
    8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBD,8'h6F,8'hBE,
    8'h70,8'h63,8'hBF,8'h79,8'hE4,8'h78,8'hE5,8'hC0,
    8'hC1,8'hE6,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7
  };

  typedef struct packed {
    logic        rep_enable;
    logic [15:0] rep_delay;
    logic [15:0] rep_period;
    logic [7:0]  beep_ticks;
  } key_cfg_t;

  typedef struct packed {
    logic       ready;
    logic [2:0] code;
    logic       repeating;
    logic       buzzer;
  } key_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrk_timers.sv -----
// Seconds and blink reload counters, stepped once per accepted tick word.
// Depends on lrk_pkg.
`default_nettype none

module lrk_timers
  import lrk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire logic [15:0] second_ticks_i,
  input  wire logic [15:0] blink_ticks_i,
  output logic             pulse_o,
  output logic             blink_o
);

  logic [15:0] sec_cnt_q, sec_cnt_d, sec_dec;
  logic [15:0] blink_cnt_q, blink_cnt_d, blink_dec;
  logic        blink_q, blink_d;

  always_comb begin
    sec_dec     = sec_cnt_q - 16'd1;
    blink_dec   = blink_cnt_q - 16'd1;
    sec_cnt_d   = sec_cnt_q;
    blink_cnt_d = blink_cnt_q;
    blink_d     = blink_q;
    pulse_o     = 1'b0;
    if (tick_i) begin
      sec_cnt_d = sec_dec;
      if (sec_dec == 16'd0) begin
        pulse_o   = 1'b1;
        sec_cnt_d = second_ticks_i;
      end
      blink_cnt_d = blink_dec;
      if (blink_dec == 16'd0) begin
        blink_d     = !blink_q;
        blink_cnt_d = blink_ticks_i;
      end
    end
  end

  assign blink_o = blink_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_cnt_q   <= SecondTicksRst;
      blink_cnt_q <= BlinkCntRst;
      blink_q     <= 1'b0;
    end else begin
      sec_cnt_q   <= sec_cnt_d;
      blink_cnt_q <= blink_cnt_d;
      blink_q     <= blink_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lrk_keyscan.sv -----
// Keypad column scan, debounce flags, repeat delay/period counter and beep.
// Depends on lrk_pkg (key_cfg_t, key_status_t).
`default_nettype none

module lrk_keyscan
  import lrk_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 tick_i,
  input  wire logic                 take_i,
  input  wire logic [KeyLinesW-1:0] key_lines_i,
  input  wire key_cfg_t             cfg_i,
  output key_status_t               status_o
);

  logic [ColW-1:0]       col_q, col_d;
  logic [KeyColumns-1:0] down_q, down_d;
  logic [2:0]            held_q, held_d;
  logic                  wait_q, wait_d;
  logic                  dly_run_q, dly_run_d;
  logic                  dly_done_q, dly_done_d;
  logic                  rep_q, rep_d;
  logic [15:0]           rep_cnt_q, rep_cnt_d, rep_dec;
  logic                  beep_q, beep_d;
  logic [7:0]            beep_cnt_q, beep_cnt_d, beep_dec;
  logic                  buz_q, buz_d;
  logic [7:0]            lines_ext;
  logic                  pressed, was_down;
  logic [2:0]            code;

  assign lines_ext = {{(8 - KeyLinesW){1'b1}}, key_lines_i};
  assign pressed   = !lines_ext[3'(col_q)];
  assign was_down  = down_q[col_q];
  assign code      = 3'(KeyColumns - int'(col_q));
  assign rep_dec   = rep_cnt_q - 16'd1;
  assign beep_dec  = beep_cnt_q - 8'd1;

  always_comb begin
    col_d      = col_q;
    down_d     = down_q;
    held_d     = held_q;
    wait_d     = wait_q;
    dly_run_d  = dly_run_q;
    dly_done_d = dly_done_q;
    rep_d      = rep_q;
    rep_cnt_d  = rep_cnt_q;
    beep_d     = beep_q;
    beep_cnt_d = beep_cnt_q;
    buz_d      = buz_q;
    if (take_i) begin
      wait_d = 1'b0;
    end
    if (tick_i) begin
      if (dly_run_q) begin
        rep_cnt_d = rep_dec;
        if (rep_dec == 16'd0) begin
          dly_done_d = 1'b1;
          dly_run_d  = 1'b0;
        end
      end
      if (beep_q) begin
        buz_d      = !buz_q;
        beep_cnt_d = beep_dec;
        if (beep_dec == 8'd0) begin
          buz_d  = 1'b0;
          beep_d = 1'b0;
        end
      end
      if (pressed) begin
        if (!was_down) begin
          if (!wait_q) begin
            held_d = code;
            wait_d = 1'b1;
          end
          buz_d      = 1'b1;
          beep_d     = 1'b1;
          beep_cnt_d = cfg_i.beep_ticks;
          dly_run_d  = 1'b1;
          rep_cnt_d  = cfg_i.rep_delay;
        end else if (dly_done_d) begin
          rep_d = 1'b1;
          if (!wait_q && cfg_i.rep_enable) begin
            held_d = code;
            wait_d = 1'b1;
          end
          dly_done_d = 1'b0;
          dly_run_d  = 1'b1;
          rep_cnt_d  = cfg_i.rep_period;
        end
        down_d[col_q] = 1'b1;
      end else begin
        if (was_down) begin
          dly_run_d  = 1'b0;
          dly_done_d = 1'b0;
          rep_d      = 1'b0;
        end
        down_d[col_q] = 1'b0;
      end
      if (32'(col_q) == KeyColumns - 1) begin
        col_d = '0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  assign status_o.ready     = wait_d;
  assign status_o.code      = held_d;
  assign status_o.repeating = rep_d;
  assign status_o.buzzer    = buz_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      down_q     <= '0;
      held_q     <= '0;
      wait_q     <= 1'b0;
      dly_run_q  <= 1'b0;
      dly_done_q <= 1'b0;
      rep_q      <= 1'b0;
      rep_cnt_q  <= '0;
      beep_q     <= 1'b0;
      beep_cnt_q <= '0;
      buz_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      down_q     <= down_d;
      held_q     <= held_d;
      wait_q     <= wait_d;
      dly_run_q  <= dly_run_d;
      dly_done_q <= dly_done_d;
      rep_q      <= rep_d;
      rep_cnt_q  <= rep_cnt_d;
      beep_q     <= beep_d;
      beep_cnt_q <= beep_cnt_d;
      buz_q      <= buz_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lrk_refresh.sv -----
// Character buffer, blink masks and the LCD refresh walker that emits one
// byte per tick. Depends on lrk_pkg (sizes, CODE_TABLE).
`default_nettype none

module lrk_refresh
  import lrk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tick_i,
  input  wire logic             wr_char_i,
  input  wire logic             set_mask_i,
  input  wire logic             clear_i,
  input  wire logic [4:0]       char_addr_i,
  input  wire logic [7:0]       char_code_i,
  input  wire logic             line_sel_i,
  input  wire logic [MaskW-1:0] mask_value_i,
  input  wire logic             blink_i,
  output logic                  lcd_rs_o,
  output logic [7:0]            lcd_byte_o
);

  logic [7:0]       buf_q [BufLen];
  logic [MaskW-1:0] mask1_q, mask2_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             line2_q, line2_d;
  logic [7:0]       raw_ch, map_ch;
  logic [PosW-1:0]  col2;
  logic             blank;

  assign raw_ch = buf_q[BufIdxW'(pos_q)];
  assign map_ch = raw_ch[7] ? CODE_TABLE[raw_ch[6:0]] : raw_ch;
  assign col2   = pos_q - PosW'(LineChars);

  always_comb begin
    if (line2_q) begin
      blank = (32'(pos_q) >= LineChars) && (32'(col2) < MaskW) && mask2_q[col2[3:0]];
    end else begin
      blank = (32'(pos_q) < MaskW) && mask1_q[pos_q[3:0]];
    end
  end

  always_comb begin
    pos_d      = pos_q;
    line2_d    = line2_q;
    lcd_rs_o   = 1'b0;
    lcd_byte_o = 8'h00;
    if (tick_i) begin
      if (32'(pos_q) >= BufLen) begin
        pos_d      = '0;
        line2_d    = 1'b0;
        lcd_byte_o = LcdLineOne;
      end else if (32'(pos_q) == LineChars && !line2_q) begin
        line2_d    = 1'b1;
        lcd_byte_o = LcdLineTwo;
      end else begin
        lcd_rs_o   = 1'b1;
        lcd_byte_o = (blank && blink_i) ? ChSpace : map_ch;
        pos_d      = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      line2_q <= 1'b0;
      mask1_q <= '0;
      mask2_q <= '0;
      for (int i = 0; i < BufLen; i++) begin
        buf_q[i] <= ChSpace;
      end
    end else begin
      pos_q   <= pos_d;
      line2_q <= line2_d;
      if (clear_i) begin
        mask1_q <= '0;
        mask2_q <= '0;
        for (int i = 0; i < BufLen; i++) begin
          buf_q[i] <= ChSpace;
        end
      end
      if (set_mask_i) begin
        if (line_sel_i) begin
          mask2_q <= mask_value_i;
        end else begin
          mask1_q <= mask_value_i;
        end
      end
      if (wr_char_i && (32'(char_addr_i) < BufLen) && (char_code_i != 8'h00)) begin
        buf_q[BufIdxW'(char_addr_i)] <= char_code_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcd_refresh_keypad_scanner.sv -----
// LCD refresh and keypad scanner. Takes one word per clock unless the input
// stalls, and shows its result in the cycle after the accept edge: all state
// updates happen at the accept edge and the result word is held in a single
// output register, which is the only stage. The input stalls only while that
// register holds a word the receiver is stalling. Configuration writes are
// always ready. The character buffer is in flip-flops, so no clearing pass
// follows reset. Depends on lrk_pkg, lrk_timers, lrk_keyscan, lrk_refresh.
`default_nettype none

module lcd_refresh_keypad_scanner
  import lrk_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CmdW-1:0]      cmd_i,
  input  wire logic [KeyLinesW-1:0] key_lines_i,
  input  wire logic [4:0]           char_addr_i,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 line_sel_i,
  input  wire logic [MaskW-1:0]     mask_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      lcd_valid_o,
  output logic                      lcd_rs_o,
  output logic [7:0]                lcd_byte_o,
  output logic                      key_ready_o,
  output logic [2:0]                key_code_o,
  output logic                      key_repeating_o,
  output logic                      buzzer_on_o,
  output logic                      seconds_pulse_o,
  output logic                      blink_phase_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  logic        auto_rep_q;
  logic [15:0] second_ticks_q, blink_ticks_q, rep_delay_q, rep_period_q;
  logic [7:0]  beep_ticks_q;

  logic        in_acc, is_tick, cfg_acc;
  cmd_e        cmd;
  key_cfg_t    key_cfg;
  key_status_t key_st;
  logic        pulse, blink, rs;
  logic [7:0]  lcd_byte;

  logic        out_valid_q;
  logic        lcd_valid_q, lcd_rs_q, pulse_q, blink_q;
  logic [7:0]  lcd_byte_q;
  key_status_t key_st_q;

  assign cmd         = cmd_e'(cmd_i);
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_tick     = in_acc && (cmd == CMD_TICK);
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_rep_q     <= 1'b0;
      second_ticks_q <= SecondTicksRst;
      blink_ticks_q  <= BlinkTicksRst;
      rep_delay_q    <= RepDelayRst;
      rep_period_q   <= RepPeriodRst;
      beep_ticks_q   <= BeepTicksRst;
    end else if (cfg_acc) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REPEAT_EN:    auto_rep_q     <= cfg_data_i[0];
        CFG_SECOND_TICKS: second_ticks_q <= cfg_data_i;
        CFG_BLINK_TICKS:  blink_ticks_q  <= cfg_data_i;
        CFG_REP_DELAY:    rep_delay_q    <= cfg_data_i;
        CFG_REP_PERIOD:   rep_period_q   <= cfg_data_i;
        CFG_BEEP_TICKS:   beep_ticks_q   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign key_cfg.rep_enable  = auto_rep_q;
  assign key_cfg.rep_delay   = rep_delay_q;
  assign key_cfg.rep_period  = rep_period_q;
  assign key_cfg.beep_ticks  = beep_ticks_q;

  lrk_timers u_timers (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (is_tick),
    .second_ticks_i (second_ticks_q),
    .blink_ticks_i  (blink_ticks_q),
    .pulse_o        (pulse),
    .blink_o        (blink)
  );

  lrk_keyscan u_keyscan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (is_tick),
    .take_i      (in_acc && (cmd == CMD_TAKE_KEY)),
    .key_lines_i (key_lines_i),
    .cfg_i       (key_cfg),
    .status_o    (key_st)
  );

  lrk_refresh u_refresh (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (is_tick),
    .wr_char_i    (in_acc && (cmd == CMD_WRITE_CHAR)),
    .set_mask_i   (in_acc && (cmd == CMD_SET_MASK)),
    .clear_i      (in_acc && (cmd == CMD_CLEAR)),
    .char_addr_i  (char_addr_i),
    .char_code_i  (char_code_i),
    .line_sel_i   (line_sel_i),
    .mask_value_i (mask_value_i),
    .blink_i      (blink),
    .lcd_rs_o     (rs),
    .lcd_byte_o   (lcd_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lcd_valid_q <= is_tick;
      lcd_rs_q    <= rs;
      lcd_byte_q  <= lcd_byte;
      pulse_q     <= pulse;
      blink_q     <= blink;
      key_st_q    <= key_st;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lcd_valid_o     = lcd_valid_q;
  assign lcd_rs_o        = lcd_rs_q;
  assign lcd_byte_o      = lcd_byte_q;
  assign key_ready_o     = key_st_q.ready;
  assign key_code_o      = key_st_q.code;
  assign key_repeating_o = key_st_q.repeating;
  assign buzzer_on_o     = key_st_q.buzzer;
  assign seconds_pulse_o = pulse_q;
  assign blink_phase_o   = blink_q;

  a_non_tick_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd != CMD_TICK)) |=> (!lcd_valid_q && !lcd_rs_q && !pulse_q))
    else $error("non-tick word produced an LCD byte or pulse");

  a_cmd_byte_is_line_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && lcd_valid_q && !lcd_rs_q) |->
      ((lcd_byte_q == LcdLineOne) || (lcd_byte_q == LcdLineTwo)))
    else $error("LCD command byte is not a line address");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled with a free output register");

endmodule

`default_nettype wire

// ----- bench/lcd_refresh_keypad_scanner_tb.sv -----
// Self-checking testbench for lcd_refresh_keypad_scanner: a directed table, then random
// phases under several register settings and handshake idling, checked by a predictor
// save fixed table rows. Depends on lrk_pkg and the RTL of lcd_refresh_keypad_scanner.
`default_nettype none

module lcd_refresh_keypad_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrk_pkg::*;

  localparam int ClkPeriod = 10;

  localparam logic [CmdW-1:0]    CmdSpareFirst = CmdW'(CMD_TAKE_KEY + 1);
  localparam logic [CmdW-1:0]    CmdSpareLast  = '1;
  localparam logic [CfgIdxW-1:0] CfgSpareFirst = CfgIdxW'(CFG_BEEP_TICKS + 1);
  localparam logic [CfgIdxW-1:0] CfgSpareLast  = '1;

  localparam logic [7:0]  SpaceChar   = 8'h20;
  localparam logic [7:0]  LineOneAddr = 8'h80;
  localparam logic [7:0]  LineTwoAddr = 8'hC0;
  localparam logic [15:0] SecondsInit = 16'd1000;
  localparam logic [15:0] BlinkInit   = 16'd300;
  localparam logic [15:0] BlinkStart  = 16'd500;
  localparam logic [15:0] DelayInit   = 16'd700;
  localparam logic [15:0] PeriodInit  = 16'd150;
  localparam logic [7:0]  BeepInit    = 8'd100;

  localparam logic [7:0] HighCharMap [128] = '{
    8'hD9,8'hDA,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'hA2,8'hB5,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h41,8'hA0,8'h42,8'hA1,8'hE0,8'h45,8'hA3,8'hA4,8'hA5,8'hA6,8'h4B,8'hA7,8'h4D,8'h48,8'h4F,8'hA8,
    8'h50,8'h43,8'h54,8'hA9,8'hAA,8'h58,8'hE1,8'hAB,8'hAC,8'hE2,8'hAD,8'hAE,8'h62,8'hAF,8'hB0,8'hB1,
    8'h61,8'hB2,8'hB3,8'hB4,8'hE3,8'h65,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBD,8'h6F,8'hBE,
    8'h70,8'h63,8'hBF,8'h79,8'hE4,8'h78,8'hE5,8'hC0,8'hC1,8'hE6,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7
  };

  typedef struct packed {
    logic [CmdW-1:0]      cmd;
    logic [KeyLinesW-1:0] key_lines;
    logic [4:0]           char_addr;
    logic [7:0]           char_code;
    logic                 line_sel;
    logic [MaskW-1:0]     mask_value;
  } item_t;

  typedef struct packed {
    logic       lcd_valid;
    logic       lcd_rs;
    logic [7:0] lcd_byte;
    logic       key_ready;
    logic [2:0] key_code;
    logic       key_repeating;
    logic       buzzer_on;
    logic       seconds_pulse;
    logic       blink_phase;
  } word_t;

  typedef struct packed {
    item_t item;
    logic  fixed;
    word_t want;
  } row_t;

  localparam word_t Quiet     = '0;
  localparam word_t FirstChar = '{1'b1, 1'b1, 8'h20, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0};

  localparam int DirRows = 25;
  localparam row_t DirectedRows [DirRows] = '{
    '{'{CMD_TICK,       4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b1, FirstChar},
    '{'{CMD_TAKE_KEY,   4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CmdSpareFirst,  4'h0, 5'd31, 8'hFF, 1'b1, 16'hFFFF}, 1'b1, Quiet},
    '{'{CmdSpareLast,   4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_WRITE_CHAR, 4'hF, 5'd2,  8'hFF, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_WRITE_CHAR, 4'hF, 5'd3,  8'h80, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_WRITE_CHAR, 4'hF, 5'd4,  8'h00, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_WRITE_CHAR, 4'hF, 5'd31, 8'h7F, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_WRITE_CHAR, 4'hF, 5'd0,  8'h01, 1'b0, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_SET_MASK,   4'hF, 5'd0,  8'h00, 1'b0, 16'hFFFF}, 1'b1, Quiet},
    '{'{CMD_SET_MASK,   4'hF, 5'd0,  8'h00, 1'b1, 16'h0000}, 1'b1, Quiet},
    '{'{CMD_TICK,       4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TAKE_KEY,   4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h0, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_CLEAR,      4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_SET_MASK,   4'hF, 5'd0,  8'h00, 1'b1, 16'h8001}, 1'b0, Quiet},
    '{'{CMD_TAKE_KEY,   4'hF, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet},
    '{'{CMD_TICK,       4'h5, 5'd0,  8'h00, 1'b0, 16'h0000}, 1'b0, Quiet}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CmdW-1:0]      cmd_i = '0;
  logic [KeyLinesW-1:0] key_lines_i = '1;
  logic [4:0]           char_addr_i = '0;
  logic [7:0]           char_code_i = '0;
  logic                 line_sel_i = 1'b0;
  logic [MaskW-1:0]     mask_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 lcd_valid_o;
  logic                 lcd_rs_o;
  logic [7:0]           lcd_byte_o;
  logic                 key_ready_o;
  logic [2:0]           key_code_o;
  logic                 key_repeating_o;
  logic                 buzzer_on_o;
  logic                 seconds_pulse_o;
  logic                 blink_phase_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  lcd_refresh_keypad_scanner i_dut (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // register copies
  logic        cfg_auto;
  logic [15:0] cfg_second, cfg_blink, cfg_rep_delay, cfg_rep_period;
  logic [7:0]  cfg_beep;

  // predicted block state
  logic [7:0]          screen [BufLen];
  logic [MaskW-1:0]    mask_one, mask_two;
  logic [PosW-1:0]     refresh_pos;
  logic                line_two;
  logic [15:0]         sec_left, blink_left, rep_left;
  logic                blink_on;
  logic [ColW-1:0]     scan_col;
  logic [KeyColumns-1:0] keys_down;
  logic [2:0]          latched_code;
  logic                code_pending, delay_run, delay_expired, repeating;
  logic                beep_run, buzz;
  logic [7:0]          beep_left;

  word_t       panel_words_q [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned lcd_bytes = 0;
  int unsigned pulses_seen = 0;
  int unsigned repeat_words = 0;
  int unsigned settings_used = 1;
  logic [KeyLinesW-1:0] key_pattern = '1;

  task automatic panel_reset();
    cfg_auto = 1'b0;
    cfg_second = SecondsInit;
    cfg_blink = BlinkInit;
    cfg_rep_delay = DelayInit;
    cfg_rep_period = PeriodInit;
    cfg_beep = BeepInit;
    foreach (screen[i]) screen[i] = SpaceChar;
    mask_one = '0;
    mask_two = '0;
    refresh_pos = '0;
    line_two = 1'b0;
    sec_left = SecondsInit;
    blink_left = BlinkStart;
    blink_on = 1'b0;
    scan_col = '0;
    keys_down = '0;
    latched_code = '0;
    code_pending = 1'b0;
    delay_run = 1'b0;
    delay_expired = 1'b0;
    repeating = 1'b0;
    rep_left = '0;
    beep_run = 1'b0;
    beep_left = '0;
    buzz = 1'b0;
  endtask

  task automatic panel_step(input item_t it, output word_t w);
    logic [KeyColumns-1:0] col_bit;
    logic                  pressed, was_down, blank;
    logic [2:0]            key_id;
    logic [7:0]            ch;
    int unsigned           offs;
    w = '0;
    case (it.cmd)
      CMD_TICK: begin
        sec_left = sec_left - 16'd1;
        if (sec_left == '0) begin
          w.seconds_pulse = 1'b1;
          sec_left = cfg_second;
        end
        blink_left = blink_left - 16'd1;
        if (blink_left == '0) begin
          blink_on = !blink_on;
          blink_left = cfg_blink;
        end
        if (delay_run) begin
          rep_left = rep_left - 16'd1;
          if (rep_left == '0) begin
            delay_expired = 1'b1;
            delay_run = 1'b0;
          end
        end
        if (beep_run) begin
          buzz = !buzz;
          beep_left = beep_left - 8'd1;
          if (beep_left == '0) begin
            buzz = 1'b0;
            beep_run = 1'b0;
          end
        end
        col_bit = '0;
        col_bit[scan_col] = 1'b1;
        pressed = (int'(scan_col) < KeyLinesW) && !it.key_lines[scan_col];
        was_down = |(keys_down & col_bit);
        key_id = 3'(KeyColumns - int'(scan_col));
        if (pressed) begin
          if (!was_down) begin
            if (!code_pending) begin
              latched_code = key_id;
              code_pending = 1'b1;
            end
            buzz = 1'b1;
            beep_run = 1'b1;
            beep_left = cfg_beep;
            delay_run = 1'b1;
            rep_left = cfg_rep_delay;
          end else if (delay_expired) begin
            repeating = 1'b1;
            if (!code_pending && cfg_auto) begin
              latched_code = key_id;
              code_pending = 1'b1;
            end
            delay_expired = 1'b0;
            delay_run = 1'b1;
            rep_left = cfg_rep_period;
          end
          keys_down = keys_down | col_bit;
        end else begin
          if (was_down) begin
            delay_run = 1'b0;
            delay_expired = 1'b0;
            repeating = 1'b0;
          end
          keys_down = keys_down & ~col_bit;
        end
        scan_col = (int'(scan_col) >= KeyColumns - 1) ? '0 : scan_col + 1'b1;
        w.lcd_valid = 1'b1;
        if (int'(refresh_pos) >= BufLen) begin
          refresh_pos = '0;
          line_two = 1'b0;
          w.lcd_byte = LineOneAddr;
        end else if (int'(refresh_pos) == LineChars && !line_two) begin
          line_two = 1'b1;
          w.lcd_byte = LineTwoAddr;
        end else begin
          ch = screen[refresh_pos];
          if (ch[7]) ch = HighCharMap[ch[6:0]];
          offs = int'(refresh_pos) - LineChars;
          if (line_two)
            blank = int'(refresh_pos) >= LineChars && offs < MaskW && mask_two[offs];
          else
            blank = int'(refresh_pos) < MaskW && mask_one[refresh_pos];
          if (blank && blink_on) ch = SpaceChar;
          w.lcd_rs = 1'b1;
          w.lcd_byte = ch;
          refresh_pos = refresh_pos + 1'b1;
        end
      end
      CMD_WRITE_CHAR: begin
        if (int'(it.char_addr) < BufLen && it.char_code != '0) screen[it.char_addr] = it.char_code;
      end
      CMD_SET_MASK: begin
        if (!it.line_sel) mask_one = it.mask_value;
        else mask_two = it.mask_value;
      end
      CMD_CLEAR: begin
        foreach (screen[i]) screen[i] = SpaceChar;
        mask_one = '0;
        mask_two = '0;
      end
      CMD_TAKE_KEY: begin
        code_pending = 1'b0;
      end
      default: ;
    endcase
    w.key_ready = code_pending;
    w.key_code = latched_code;
    w.key_repeating = repeating;
    w.buzzer_on = buzz;
    w.blink_phase = blink_on;
  endtask

  task automatic present(input item_t it);
    cmd_i <= it.cmd;
    key_lines_i <= it.key_lines;
    char_addr_i <= it.char_addr;
    char_code_i <= it.char_code;
    line_sel_i <= it.line_sel;
    mask_value_i <= it.mask_value;
  endtask

  task automatic random_fields(output item_t it);
    it.cmd = 3'($urandom);
    it.key_lines = 4'($urandom);
    it.char_addr = 5'($urandom);
    it.char_code = 8'($urandom);
    it.line_sel = 1'($urandom);
    it.mask_value = 16'($urandom);
  endtask

  task automatic send_item(input item_t it, input logic fixed, input word_t want);
    item_t noise;
    word_t w;
    while ($urandom_range(99) < idle_pct) begin
      random_fields(noise);
      in_valid_i <= 1'b0;
      present(noise);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    present(it);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    panel_step(it, w);
    panel_words_q.push_back(fixed ? want : w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (panel_words_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_REPEAT_EN:    cfg_auto = data[0];
      CFG_SECOND_TICKS: cfg_second = data;
      CFG_BLINK_TICKS:  cfg_blink = data;
      CFG_REP_DELAY:    cfg_rep_delay = data;
      CFG_REP_PERIOD:   cfg_rep_period = data;
      CFG_BEEP_TICKS:   cfg_beep = data[7:0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic apply_setting(input logic auto_rep, input logic [15:0] sec, input logic [15:0] blink,
                               input logic [15:0] delay, input logic [15:0] period,
                               input logic [7:0] beep);
    write_reg(CFG_REPEAT_EN, {15'($urandom), auto_rep});
    write_reg(CFG_SECOND_TICKS, sec);
    write_reg(CFG_BLINK_TICKS, blink);
    write_reg(CFG_REP_DELAY, delay);
    write_reg(CFG_REP_PERIOD, period);
    write_reg(CFG_BEEP_TICKS, {8'($urandom), beep});
    write_reg(3'($urandom_range(CfgSpareFirst, CfgSpareLast)), 16'($urandom));
    settings_used++;
  endtask

  task automatic make_item(output item_t it);
    int unsigned pick;
    random_fields(it);
    pick = $urandom_range(99);
    if (pick < 68) begin
      it.cmd = CMD_TICK;
      if ($urandom_range(99) < 7) begin
        case ($urandom_range(4))
          0, 1: key_pattern = '1;
          2, 3: key_pattern = ~(4'b0001 << $urandom_range(KeyColumns - 1));
          default: key_pattern = 4'($urandom);
        endcase
      end
      if ($urandom_range(99) >= 5) it.key_lines = key_pattern;
    end else if (pick < 78) begin
      it.cmd = CMD_WRITE_CHAR;
      if ($urandom_range(9) == 0) it.char_code = '0;
      else if ($urandom_range(2) == 0) it.char_code[7] = 1'b1;
    end else if (pick < 84) begin
      it.cmd = CMD_SET_MASK;
      if ($urandom_range(3) == 0) it.mask_value = '1;
    end else if (pick < 86) begin
      it.cmd = CMD_CLEAR;
    end else if (pick < 97) begin
      it.cmd = CMD_TAKE_KEY;
    end else begin
      it.cmd = 3'($urandom_range(CmdSpareFirst, CmdSpareLast));
    end
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned idle,
                           input int unsigned stall);
    item_t       it;
    int unsigned done;
    logic        paused;
    idle_pct = idle;
    stall_pct = stall;
    done = 0;
    paused = 1'b0;
    while (done < items) begin
      make_item(it);
      send_item(it, 1'b0, Quiet);
      if (it.cmd <= CMD_TAKE_KEY) done++;
      if (!paused && done >= items / 2) begin
        paused = 1'b1;
        drain();
      end
    end
    drain();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    word_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{lcd_valid_o, lcd_rs_o, lcd_byte_o, key_ready_o, key_code_o, key_repeating_o,
              buzzer_on_o, seconds_pulse_o, blink_phase_o};
      if (panel_words_q.size() == 0) begin
        $error("word with nothing expected: 0x%0h", got);
        mismatches++;
      end else begin
        want = panel_words_q.pop_front();
        check_field("lcd_valid", 8'(want.lcd_valid), 8'(got.lcd_valid));
        check_field("lcd_rs", 8'(want.lcd_rs), 8'(got.lcd_rs));
        check_field("lcd_byte", want.lcd_byte, got.lcd_byte);
        check_field("key_ready", 8'(want.key_ready), 8'(got.key_ready));
        check_field("key_code", 8'(want.key_code), 8'(got.key_code));
        check_field("key_repeating", 8'(want.key_repeating), 8'(got.key_repeating));
        check_field("buzzer_on", 8'(want.buzzer_on), 8'(got.buzzer_on));
        check_field("seconds_pulse", 8'(want.seconds_pulse), 8'(got.seconds_pulse));
        check_field("blink_phase", 8'(want.blink_phase), 8'(got.blink_phase));
      end
      words_checked++;
      if (got.lcd_valid) lcd_bytes++;
      if (got.seconds_pulse) pulses_seen++;
      if (got.key_repeating) repeat_words++;
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    panel_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedRows[i])
      send_item(DirectedRows[i].item, DirectedRows[i].fixed, DirectedRows[i].want);
    drain();
    apply_setting(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd1);
    run_phase(105, 0, 0);
    apply_setting(1'b1, 16'd7, 16'd3, 16'd9, 16'd3, 8'd4);
    run_phase(105, 63, 0);
    apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_phase(105, 0, 63);
    // zero reloads count a full wrap of the counter
    apply_setting(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    run_phase(105, 38, 38);
    apply_setting(1'b1, 16'($urandom_range(1, 20)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(1, 30)), 16'($urandom_range(1, 10)),
                  8'($urandom_range(1, 8)));
    run_phase(105, 38, 38);
    apply_setting(1'($urandom), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
                  16'($urandom_range(1, 20)), 16'($urandom_range(1, 6)),
                  8'($urandom_range(1, 16)));
    run_phase(105, 20, 20);
    $display("checked %0d words, %0d of them LCD bytes, under %0d register settings",
             words_checked, lcd_bytes, settings_used);
    $display("seen %0d seconds pulses and %0d words with a key in auto-repeat",
             pulses_seen, repeat_words);
    if (mismatches == 0) begin
      $display("lcd_refresh_keypad_scanner_tb OK");
    end else begin
      $display("lcd_refresh_keypad_scanner_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("lcd_refresh_keypad_scanner_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/lrk_pkg.sv
rtl/core/lrk_timers.sv
rtl/core/lrk_keyscan.sv
rtl/core/lrk_refresh.sv
rtl/core/lcd_refresh_keypad_scanner.sv
bench/lcd_refresh_keypad_scanner_tb.sv
